// ===== hw/rtl/pfa_pkg.sv =====
// Shared types and constants of the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

	localparam int MAX_PAGES_DEF  = 4096;
	localparam int PAGE_SHIFT_DEF = 12;
	localparam int PC_W           = 13;
	localparam logic [PC_W-1:0] FRAME_TOTAL_RESET = 13'd4096;

	localparam logic [7:0] CNT_RESERVED = 8'd255;
	localparam logic [7:0] CNT_ONE      = 8'd1;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_INIT    = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OOM = 2'd1;
	localparam logic [1:0] ST_NIU = 2'd2;

	typedef struct packed {
		logic [1:0]      status;
		logic [31:0]     page_address;
		logic [7:0]      count_after;
		logic [PC_W-1:0] pages_in_use;
	} res_t;

endpackage

// ===== hw/rtl/pfa_ram.sv =====
// Synchronous single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module pfa_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/pfa_ctrl.sv =====
// Sequencer that walks the reference count and free list memories.
`timescale 1ns / 1ps
module pfa_ctrl import pfa_pkg::*; #(
	parameter int MAX_PAGES  = MAX_PAGES_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [31:0]                  address,
	input  logic [31:0]                  upper_address,
	input  logic [PC_W-1:0]              frame_total,
	output logic                         res_valid,
	input  logic                         res_take,
	output res_t                         res,
	output logic                         cnt_we,
	output logic [$clog2(MAX_PAGES)-1:0] cnt_waddr,
	output logic [7:0]                   cnt_wdata,
	output logic [$clog2(MAX_PAGES)-1:0] cnt_raddr,
	input  logic [7:0]                   cnt_rdata,
	output logic                         nxt_we,
	output logic [$clog2(MAX_PAGES)-1:0] nxt_waddr,
	output logic [$clog2(MAX_PAGES)-1:0] nxt_wdata,
	output logic [$clog2(MAX_PAGES)-1:0] nxt_raddr,
	input  logic [$clog2(MAX_PAGES)-1:0] nxt_rdata,
	output logic                         prv_we,
	output logic [$clog2(MAX_PAGES)-1:0] prv_waddr,
	output logic [$clog2(MAX_PAGES)-1:0] prv_wdata,
	output logic [$clog2(MAX_PAGES)-1:0] prv_raddr,
	input  logic [$clog2(MAX_PAGES)-1:0] prv_rdata
);
	localparam int IW = $clog2(MAX_PAGES);
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam int XW = 33;
	localparam logic [31:0] OFS_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_AL_EV, S_FR_EV, S_FR_P1, S_FR_P2,
		S_RS_CRD, S_RS_CEV, S_RS_RD, S_RS_EV
	} state_t;

	state_t          state_q, state_d;
	logic [IW-1:0]   head_q, head_d;
	logic            empty_q, empty_d;
	logic [PC_W-1:0] used_q, used_d;
	logic [IW-1:0]   cur_q, cur_d;
	logic [IW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   len_q, len_d;
	logic [CW-1:0]   k_q, k_d;
	logic [XW-1:0]   lo_q, lo_d, hi_q, hi_d;
	logic [IW-1:0]   ini_q, ini_d;
	logic [CW-1:0]   inn_q, inn_d;
	logic            ini_res_q, ini_res_d;
	logic            pend_q, pend_d;
	res_t            res_q, res_d;

	logic            accept;
	logic [31:0]     addr_pg;
	logic [31:0]     pc32;
	logic [CW-1:0]   ini_p1;
	logic [CW-1:0]   ini_w;
	logic [7:0]      c_dec;
	logic            in_range;
	logic [63:0]     pa_wide;

	assign res_valid = pend_q;
	assign res       = res_q;
	assign addr_pg   = address >> PAGE_SHIFT;
	assign pc32      = 32'(frame_total);
	assign ini_w     = CW'(ini_q);
	assign ini_p1    = ini_w + CW'(1);
	assign c_dec     = cnt_rdata - 8'd1;
	assign in_range  = (XW'(cur_q) >= lo_q) && (XW'(cur_q) <= hi_q);
	assign pa_wide   = 64'(head_q) << PAGE_SHIFT;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		empty_d   = empty_q;
		used_d    = used_q;
		cur_d     = cur_q;
		idx_d     = idx_q;
		len_d     = len_q;
		k_d       = k_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		ini_d     = ini_q;
		inn_d     = inn_q;
		ini_res_d = ini_res_q;
		pend_d    = pend_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = idx_q;
		cnt_wdata = 8'd0;
		cnt_raddr = IW'(addr_pg);
		nxt_we    = 1'b0;
		nxt_waddr = cur_q;
		nxt_wdata = cur_q;
		nxt_raddr = cur_q;
		prv_we    = 1'b0;
		prv_waddr = cur_q;
		prv_wdata = cur_q;
		prv_raddr = cur_q;

		case (state_q)
			S_IDLE: begin
				nxt_raddr = head_q;
				prv_raddr = head_q;
				if (pend_q && res_take) begin
					pend_d = 1'b0;
				end
				in_ready = !pend_q || res_take;
				accept   = in_ready && in_valid;
				if (accept) begin
					res_d = '{status: ST_OK, page_address: 32'd0, count_after: 8'd0,
						pages_in_use: used_q};
					case (op_t'(opcode))
						OP_ALLOC: begin
							if (empty_q) begin
								res_d.status = ST_OOM;
								pend_d = 1'b1;
							end else begin
								state_d = S_AL_EV;
							end
						end
						OP_FREE: begin
							if (addr_pg >= 32'(MAX_PAGES)) begin
								res_d.status = ST_NIU;
								pend_d = 1'b1;
							end else begin
								idx_d   = IW'(addr_pg);
								state_d = S_FR_EV;
							end
						end
						OP_RESERVE: begin
							lo_d = XW'(addr_pg);
							hi_d = XW'(upper_address >> PAGE_SHIFT)
								+ XW'((upper_address & OFS_MASK) != 32'd0);
							if (empty_q) begin
								pend_d = 1'b1;
							end else begin
								cur_d   = head_q;
								len_d   = '0;
								state_d = S_RS_CEV;
							end
						end
						OP_INIT: begin
							ini_d     = '0;
							ini_res_d = 1'b1;
							if (pc32 < 32'd2) begin
								inn_d = CW'(2);
							end else if (pc32 > 32'(MAX_PAGES)) begin
								inn_d = CW'(MAX_PAGES);
							end else begin
								inn_d = CW'(pc32);
							end
							state_d = S_INIT;
						end
						default: begin
							pend_d = 1'b1;
						end
					endcase
				end
			end
			S_INIT: begin
				cnt_we    = 1'b1;
				cnt_waddr = ini_q;
				cnt_wdata = (ini_q == '0) ? CNT_RESERVED : 8'd0;
				nxt_we    = 1'b1;
				nxt_waddr = ini_q;
				prv_we    = 1'b1;
				prv_waddr = ini_q;
				if (ini_w >= CW'(1) && ini_w < inn_q) begin
					nxt_wdata = (ini_p1 < inn_q) ? IW'(ini_p1) : IW'(1);
					prv_wdata = (ini_w > CW'(1)) ? IW'(ini_w - CW'(1))
						: IW'(inn_q - CW'(1));
				end else begin
					nxt_wdata = ini_q;
					prv_wdata = ini_q;
				end
				ini_d = ini_q + IW'(1);
				if (ini_q == IW'(MAX_PAGES - 1)) begin
					head_d  = IW'(1);
					empty_d = 1'b0;
					used_d  = PC_W'(1);
					if (ini_res_q) begin
						res_d = '{status: ST_OK, page_address: 32'd0, count_after: 8'd0,
							pages_in_use: PC_W'(1)};
						pend_d = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_AL_EV: begin
				if (nxt_rdata == head_q) begin
					empty_d = 1'b1;
				end else begin
					prv_we    = 1'b1;
					prv_waddr = nxt_rdata;
					prv_wdata = prv_rdata;
					nxt_we    = 1'b1;
					nxt_waddr = prv_rdata;
					nxt_wdata = nxt_rdata;
					head_d    = nxt_rdata;
				end
				cnt_we    = 1'b1;
				cnt_waddr = head_q;
				cnt_wdata = CNT_ONE;
				used_d    = used_q + PC_W'(1);
				res_d.page_address = pa_wide[31:0];
				res_d.pages_in_use = used_d;
				pend_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_FR_EV: begin
				if (cnt_rdata == 8'd0) begin
					res_d.status = ST_NIU;
					pend_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cnt_we    = 1'b1;
					cnt_waddr = idx_q;
					cnt_wdata = c_dec;
					res_d.count_after = c_dec;
					if (c_dec != 8'd0) begin
						pend_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						// The count reached zero: the page goes back on the free head.
						used_d = used_q - PC_W'(1);
						res_d.pages_in_use = used_d;
						head_d = idx_q;
						if (empty_q) begin
							nxt_we    = 1'b1;
							nxt_waddr = idx_q;
							nxt_wdata = idx_q;
							prv_we    = 1'b1;
							prv_waddr = idx_q;
							prv_wdata = idx_q;
							empty_d   = 1'b0;
							pend_d    = 1'b1;
							state_d   = S_IDLE;
						end else begin
							prv_raddr = head_q;
							cur_d     = head_q;
							state_d   = S_FR_P1;
						end
					end
				end
			end
			S_FR_P1: begin
				nxt_we    = 1'b1;
				nxt_waddr = prv_rdata;
				nxt_wdata = idx_q;
				prv_we    = 1'b1;
				prv_waddr = idx_q;
				prv_wdata = prv_rdata;
				state_d   = S_FR_P2;
			end
			S_FR_P2: begin
				nxt_we    = 1'b1;
				nxt_waddr = idx_q;
				nxt_wdata = cur_q;
				prv_we    = 1'b1;
				prv_waddr = cur_q;
				prv_wdata = idx_q;
				pend_d    = 1'b1;
				state_d   = S_IDLE;
			end
			S_RS_CRD: begin
				state_d = S_RS_CEV;
			end
			S_RS_CEV: begin
				// First pass only measures the length of the free ring.
				len_d = len_q + CW'(1);
				if (nxt_rdata == head_q || len_d == CW'(MAX_PAGES)) begin
					cur_d   = head_q;
					k_d     = '0;
					state_d = S_RS_RD;
				end else begin
					cur_d   = nxt_rdata;
					state_d = S_RS_CRD;
				end
			end
			S_RS_RD: begin
				state_d = S_RS_EV;
			end
			S_RS_EV: begin
				if (in_range) begin
					if (nxt_rdata == cur_q) begin
						empty_d = 1'b1;
					end else begin
						prv_we    = 1'b1;
						prv_waddr = nxt_rdata;
						prv_wdata = prv_rdata;
						nxt_we    = 1'b1;
						nxt_waddr = prv_rdata;
						nxt_wdata = nxt_rdata;
						if (head_q == cur_q) begin
							head_d = nxt_rdata;
						end
					end
					cnt_we    = 1'b1;
					cnt_waddr = cur_q;
					cnt_wdata = CNT_RESERVED;
					used_d    = used_q + PC_W'(1);
				end
				cur_d = nxt_rdata;
				k_d   = k_q + CW'(1);
				if (k_d == len_q) begin
					res_d.pages_in_use = used_d;
					pend_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_RS_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			head_q    <= IW'(1);
			empty_q   <= 1'b0;
			used_q    <= PC_W'(1);
			ini_q     <= '0;
			inn_q     <= CW'(MAX_PAGES);
			ini_res_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			empty_q   <= empty_d;
			used_q    <= used_d;
			ini_q     <= ini_d;
			inn_q     <= inn_d;
			ini_res_q <= ini_res_d;
			pend_q    <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		idx_q <= idx_d;
		len_q <= len_d;
		k_q   <= k_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		res_q <= res_d;
	end
endmodule

// ===== hw/rtl/page_frame_allocator.sv =====
// Top level of the page frame allocator: config register, memories, output register.
//
//  Channel  Signals                                    Direction
//  in       in_valid/in_ready, opcode, address,        input
//           upper_address
//  out      out_valid/out_ready, status, page_address, output
//           count_after, pages_in_use
//  cfg      cfg_wr_en, cfg_wr_data (frame total)       input
//
// Allocate unlinks the free head, or answers from idle when the free list is empty;
// free answers from idle for an address past the memories and goes through the link
// states when the page returns to a non-empty free list. Reserve walks the free ring
// with one memory read round trip per page, once to measure the ring and once to
// unlink, and answers from idle on an empty list. Initialize sweeps every entry of
// the memories. After reset the same sweep runs with no input taken.
// One finished result can wait in the output register while the next item runs.
`timescale 1ns / 1ps
module page_frame_allocator import pfa_pkg::*; #(
	parameter int MAX_PAGES  = MAX_PAGES_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      opcode,
	input  logic [31:0]     address,
	input  logic [31:0]     upper_address,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      status,
	output logic [31:0]     page_address,
	output logic [7:0]      count_after,
	output logic [PC_W-1:0] pages_in_use,
	input  logic            cfg_wr_en,
	input  logic [PC_W-1:0] cfg_wr_data
);
	localparam int IW = $clog2(MAX_PAGES);

	logic [PC_W-1:0] frame_total_q;
	logic            out_valid_q;
	res_t            out_q;
	logic            res_valid;
	logic            res_take;
	res_t            res;

	logic            cnt_we, nxt_we, prv_we;
	logic [IW-1:0]   cnt_waddr, cnt_raddr, nxt_waddr, nxt_raddr, prv_waddr, prv_raddr;
	logic [7:0]      cnt_wdata, cnt_rdata;
	logic [IW-1:0]   nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;

	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q <= FRAME_TOTAL_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				frame_total_q <= cfg_wr_data;
			end
			if (res_take) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign page_address = out_q.page_address;
	assign count_after  = out_q.count_after;
	assign pages_in_use = out_q.pages_in_use;

	pfa_ctrl #(.MAX_PAGES(MAX_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .address, .upper_address,
		.frame_total(frame_total_q), .res_valid, .res_take, .res,
		.cnt_we, .cnt_waddr, .cnt_wdata, .cnt_raddr, .cnt_rdata,
		.nxt_we, .nxt_waddr, .nxt_wdata, .nxt_raddr, .nxt_rdata,
		.prv_we, .prv_waddr, .prv_wdata, .prv_raddr, .prv_rdata
	);

	pfa_ram #(.W(8), .DEPTH(MAX_PAGES)) u_cnt_ram (
		.clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	pfa_ram #(.W(IW), .DEPTH(MAX_PAGES)) u_nxt_ram (
		.clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rdata)
	);

	pfa_ram #(.W(IW), .DEPTH(MAX_PAGES)) u_prv_ram (
		.clk, .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(prv_raddr), .rdata(prv_rdata)
	);

`ifndef ASSERT_OFF
	// A failed operation never reports an address or a count.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> page_address == 32'd0 && count_after == 8'd0)
		else $error("failed item carries an address or count");

	// Only the three defined status codes are produced.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_OOM || status == ST_NIU)
		else $error("undefined status code");

	// A result that is offered and not taken stays stable until it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_q))
		else $error("pending result overwritten");
`endif
endmodule
